>>> sv/generational_handle_table_macros.svh
// Assertion macros for the generational handle table.
`ifndef GENERATIONAL_HANDLE_TABLE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define GTAB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define GTAB_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/gtab_pkg.sv
// Shared types and constants of the generational handle table.
package gtab_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;
  localparam int KEY_W      = 48;
  localparam int GEN_W      = 32;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_RESOLVE    = 2'd2,
    OP_CLEAR      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NULL  = 2'd1,
    ST_FULL  = 2'd2,
    ST_STALE = 2'd3
  } status_t;

  // One slot of the table as it sits in memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [GEN_W-1:0] gen;
    logic             keep;
  } slot_t;

endpackage

>>> sv/generational_handle_table.sv
// Top level of the generational handle table (slot map).
//
// Input channel s_*: one request per handshake; s_tuser carries the opcode
// (register, unregister, resolve, clear unkept). Output channel m_*: exactly
// one result per request, with status in m_tuser and the live count in m_tdata.
// Requests are handled one at a time; the next one is taken the cycle after
// the result moves to the output register. Register and unregister scan the
// used slots, one slot read per cycle from the slot RAM, and stop at the first
// match; a miss reads every used slot. A register that reuses a freed slot
// adds a free-stack read and a slot read. Clear scans all used slots and
// releases each live slot not marked keep. Resolve reads the addressed slot;
// a null handle (generation zero) or an index at or above the fill count
// gets its result without the read. The slot RAM does one read and one write
// each cycle.
// Reset empties the table at once: slots at or above the fill count read as
// empty with generation zero, so no clearing pass runs. When the receiver
// stalls the finished result waits in the output register; a new request may
// be accepted meanwhile and holds in its last state until the register frees.
`include "generational_handle_table_macros.svh"

module generational_handle_table (
  input  logic          clk,
  input  logic          rst,
  // tdata: object_key[47:0], keep_across_clear[48], handle_index[56:49],
  //        handle_generation[88:57], zero fill
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [95:0]   s_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]    s_tuser,
  // tdata: result_index[7:0], result_generation[39:8], result_key[87:40],
  //        live_entries[96:88], zero fill
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,
  // tuser: status[1:0]
  output logic [1:0]    m_tuser
);

  localparam int IDX_W = gtab_pkg::IDX_W;
  localparam int CNT_W = gtab_pkg::CNT_W;
  localparam int KEY_W = gtab_pkg::KEY_W;
  localparam int GEN_W = gtab_pkg::GEN_W;
  localparam int SLOT_W = $bits(gtab_pkg::slot_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_FETCH,
    S_DONE
  } state_t;

  state_t state, state_next;

  // Latched request
  gtab_pkg::opcode_t op, op_next;
  logic [KEY_W-1:0] key, key_next;
  logic             keep, keep_next;
  logic [GEN_W-1:0] hgen, hgen_next;

  // Scan pipeline and table counters
  logic [CNT_W-1:0] scan_addr, scan_addr_next;
  logic             chk_valid, chk_valid_next;
  logic [IDX_W-1:0] chk_idx, chk_idx_next;
  logic [IDX_W-1:0] pop_idx, pop_idx_next;
  logic [CNT_W-1:0] free_depth, free_depth_next;
  logic [CNT_W-1:0] use_cnt, use_cnt_next;
  logic [CNT_W-1:0] live_cnt, live_cnt_next;

  // Pending result and output register
  gtab_pkg::status_t res_status, res_status_next;
  logic [IDX_W-1:0]  res_idx, res_idx_next;
  logic [GEN_W-1:0]  res_gen, res_gen_next;
  logic [KEY_W-1:0]  res_key, res_key_next;
  logic              out_valid, out_valid_next;
  logic [103:0]      out_data, out_data_next;
  logic [1:0]        out_status, out_status_next;

  // Memory ports
  logic                slot_we;
  logic [IDX_W-1:0]    slot_waddr, slot_raddr;
  gtab_pkg::slot_t     slot_wdata, slot_rd;
  logic [SLOT_W-1:0]   slot_rdata;
  logic                fs_we;
  logic [IDX_W-1:0]    fs_waddr, fs_raddr, fs_wdata, fs_rdata;

  logic             issue;
  logic [GEN_W-1:0] gen_bump;
  logic [CNT_W-1:0] free_depth_m1;
  logic             alloc_busy;

  gtab_ram #(.WIDTH(SLOT_W), .DEPTH(gtab_pkg::SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  gtab_ram #(.WIDTH(IDX_W), .DEPTH(gtab_pkg::SLOT_COUNT)) u_free_ram (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  assign slot_rd       = gtab_pkg::slot_t'(slot_rdata);
  assign issue         = (scan_addr < use_cnt);
  assign gen_bump      = (slot_rd.gen == '1) ? GEN_W'(1) : slot_rd.gen + GEN_W'(1);
  assign free_depth_m1 = free_depth - CNT_W'(1);
  // A slot popped from the free stack is not yet counted as live
  assign alloc_busy    = (state == S_POP) || (state == S_FETCH);

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_status;

  // Sequence one request through scan, allocation and result
  always_comb begin
    state_next      = state;
    op_next         = op;
    key_next        = key;
    keep_next       = keep;
    hgen_next       = hgen;
    scan_addr_next  = scan_addr;
    chk_valid_next  = chk_valid;
    chk_idx_next    = chk_idx;
    pop_idx_next    = pop_idx;
    free_depth_next = free_depth;
    use_cnt_next    = use_cnt;
    live_cnt_next   = live_cnt;
    res_status_next = res_status;
    res_idx_next    = res_idx;
    res_gen_next    = res_gen;
    res_key_next    = res_key;
    out_valid_next  = out_valid && !m_tready;
    out_data_next   = out_data;
    out_status_next = out_status;

    slot_we    = 1'b0;
    slot_waddr = chk_idx;
    slot_wdata = '{key: '0, gen: gen_bump, keep: 1'b0};
    slot_raddr = scan_addr[IDX_W-1:0];
    fs_we      = 1'b0;
    fs_waddr   = free_depth[IDX_W-1:0];
    fs_wdata   = chk_idx;
    fs_raddr   = free_depth_m1[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        slot_raddr = s_tdata[56:49];
        if (s_tvalid) begin
          op_next         = gtab_pkg::opcode_t'(s_tuser);
          key_next        = s_tdata[47:0];
          keep_next       = s_tdata[48];
          hgen_next       = s_tdata[88:57];
          scan_addr_next  = '0;
          chk_valid_next  = 1'b0;
          res_status_next = gtab_pkg::ST_OK;
          res_idx_next    = '0;
          res_gen_next    = '0;
          res_key_next    = '0;
          unique case (gtab_pkg::opcode_t'(s_tuser))
            gtab_pkg::OP_REGISTER, gtab_pkg::OP_UNREGISTER: begin
              if (s_tdata[47:0] == '0) begin
                res_status_next = gtab_pkg::ST_NULL;
                state_next      = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            gtab_pkg::OP_RESOLVE: begin
              if (s_tdata[88:57] == '0) begin
                res_status_next = gtab_pkg::ST_NULL;
                state_next      = S_DONE;
              end else if ({1'b0, s_tdata[56:49]} >= use_cnt) begin
                res_status_next = gtab_pkg::ST_STALE;
                state_next      = S_DONE;
              end else begin
                state_next = S_FETCH;
              end
            end
            default: begin
              state_next = S_SCAN;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Advance the read pointer while used slots remain to be read
        if (issue) begin
          scan_addr_next = scan_addr + CNT_W'(1);
        end
        chk_valid_next = issue;
        chk_idx_next   = scan_addr[IDX_W-1:0];

        if (op == gtab_pkg::OP_CLEAR) begin
          // Release each live, unkept slot as its data returns
          if (chk_valid && slot_rd.key != '0 && !slot_rd.keep) begin
            slot_we = 1'b1;
            if (free_depth < CNT_W'(gtab_pkg::SLOT_COUNT)) begin
              fs_we           = 1'b1;
              free_depth_next = free_depth + CNT_W'(1);
            end
            if (live_cnt != '0) begin
              live_cnt_next = live_cnt - CNT_W'(1);
            end
          end
          if (!chk_valid && !issue) begin
            state_next = S_DONE;
          end
        end else if (chk_valid && slot_rd.key == key) begin
          if (op == gtab_pkg::OP_REGISTER) begin
            res_idx_next = chk_idx;
            res_gen_next = slot_rd.gen;
          end else begin
            slot_we = 1'b1;
            if (free_depth < CNT_W'(gtab_pkg::SLOT_COUNT)) begin
              fs_we           = 1'b1;
              free_depth_next = free_depth + CNT_W'(1);
            end
            if (live_cnt != '0) begin
              live_cnt_next = live_cnt - CNT_W'(1);
            end
          end
          state_next = S_DONE;
        end else if (!chk_valid && !issue) begin
          // Key not present
          state_next = S_DONE;
          if (op == gtab_pkg::OP_UNREGISTER) begin
            res_status_next = gtab_pkg::ST_STALE;
          end else if (free_depth != '0) begin
            free_depth_next = free_depth_m1;
            state_next      = S_POP;
          end else if (use_cnt < CNT_W'(gtab_pkg::SLOT_COUNT)) begin
            slot_we       = 1'b1;
            slot_waddr    = use_cnt[IDX_W-1:0];
            slot_wdata    = '{key: key, gen: GEN_W'(1), keep: keep};
            use_cnt_next  = use_cnt + CNT_W'(1);
            live_cnt_next = live_cnt + CNT_W'(1);
            res_idx_next  = use_cnt[IDX_W-1:0];
            res_gen_next  = GEN_W'(1);
          end else begin
            res_status_next = gtab_pkg::ST_FULL;
          end
        end
      end

      S_POP: begin
        // Read the slot taken from the free stack
        slot_raddr   = fs_rdata;
        pop_idx_next = fs_rdata;
        state_next   = S_FETCH;
      end

      S_FETCH: begin
        if (op == gtab_pkg::OP_REGISTER) begin
          slot_we       = 1'b1;
          slot_waddr    = pop_idx;
          slot_wdata    = '{key: key,
                            gen: (slot_rd.gen == '0) ? GEN_W'(1) : slot_rd.gen,
                            keep: keep};
          live_cnt_next = live_cnt + CNT_W'(1);
          res_idx_next  = pop_idx;
          res_gen_next  = (slot_rd.gen == '0) ? GEN_W'(1) : slot_rd.gen;
        end else if (slot_rd.gen == hgen && slot_rd.key != '0) begin
          res_key_next = slot_rd.key;
        end else begin
          res_status_next = gtab_pkg::ST_STALE;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid || m_tready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_data_next   = {7'd0, live_cnt, res_key, res_gen, res_idx};
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, counters and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chk_valid  <= 1'b0;
      free_depth <= '0;
      use_cnt    <= '0;
      live_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      chk_valid  <= chk_valid_next;
      free_depth <= free_depth_next;
      use_cnt    <= use_cnt_next;
      live_cnt   <= live_cnt_next;
      out_valid  <= out_valid_next;
    end
    op         <= op_next;
    key        <= key_next;
    keep       <= keep_next;
    hgen       <= hgen_next;
    scan_addr  <= scan_addr_next;
    chk_idx    <= chk_idx_next;
    pop_idx    <= pop_idx_next;
    res_status <= res_status_next;
    res_idx    <= res_idx_next;
    res_gen    <= res_gen_next;
    res_key    <= res_key_next;
    out_data   <= out_data_next;
    out_status <= out_status_next;
  end

  // Every used slot is either live or waiting on the free stack
  `GTAB_ASSERT_IMPLIES(a_balance, !alloc_busy, (free_depth + live_cnt == use_cnt), "bad count")
  // Write the slot RAM only while scanning or allocating
  `GTAB_ASSERT_IMPLIES(a_wr_state, slot_we, (state == S_SCAN || state == S_FETCH), "bad write")
  // The fill count never passes the table size
  `GTAB_ASSERT_ALWAYS(a_use_bound, (use_cnt <= CNT_W'(gtab_pkg::SLOT_COUNT)), "fill count overflow")

endmodule

>>> sv/gtab_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the generational handle table.
`timescale 1ns / 100ps

typedef struct {
  gtab_pkg::status_t                st;
  logic [gtab_pkg::IDX_W-1:0]       idx;
  logic [gtab_pkg::GEN_W-1:0]       gen;
  logic [gtab_pkg::KEY_W-1:0]       key;
  logic [gtab_pkg::CNT_W-1:0]       live;
} handle_result_t;

// Mirrors the slot table and checks each result against the oldest prediction.
class handle_scoreboard;
  logic [gtab_pkg::KEY_W-1:0] slot_key [gtab_pkg::SLOT_COUNT];
  logic [gtab_pkg::GEN_W-1:0] slot_gen [gtab_pkg::SLOT_COUNT];
  logic                       slot_keep [gtab_pkg::SLOT_COUNT];
  int                         free_slots [gtab_pkg::SLOT_COUNT];
  int                         free_top;
  int                         fill_count;
  int                         live_count;
  handle_result_t             pending_results[$];
  int                         mismatches;

  function new();
    for (int i = 0; i < gtab_pkg::SLOT_COUNT; i++) begin
      slot_key[i] = '0;
      slot_gen[i] = '0;
      slot_keep[i] = 1'b0;
      free_slots[i] = 0;
    end
    free_top = 0;
    fill_count = 0;
    live_count = 0;
    mismatches = 0;
  endfunction

  function int find_slot(logic [gtab_pkg::KEY_W-1:0] key);
    for (int i = 0; i < fill_count; i++)
      if (slot_key[i] == key) return i;
    return -1;
  endfunction

  function void free_slot(int i);
    slot_key[i] = '0;
    slot_keep[i] = 1'b0;
    slot_gen[i] = slot_gen[i] + 32'd1;
    // Generation wraps past zero to one
    if (slot_gen[i] == '0) slot_gen[i] = 32'd1;
    if (free_top < gtab_pkg::SLOT_COUNT) begin
      free_slots[free_top] = i;
      free_top++;
    end
    if (live_count > 0) live_count--;
  endfunction

  // Predict the result of one accepted request
  function void note_request(gtab_pkg::opcode_t op, logic [gtab_pkg::KEY_W-1:0] key,
                             logic keep, logic [gtab_pkg::IDX_W-1:0] hidx,
                             logic [gtab_pkg::GEN_W-1:0] hgen);
    handle_result_t r;
    int i;
    r.st = gtab_pkg::ST_OK;
    r.idx = '0;
    r.gen = '0;
    r.key = '0;
    case (op)
      gtab_pkg::OP_REGISTER: begin
        if (key == '0) begin
          r.st = gtab_pkg::ST_NULL;
        end else begin
          i = find_slot(key);
          if (i < 0) begin
            if (free_top > 0) begin
              free_top--;
              i = free_slots[free_top];
            end else if (fill_count < gtab_pkg::SLOT_COUNT) begin
              i = fill_count;
              fill_count++;
            end
            if (i >= 0) begin
              slot_key[i] = key;
              slot_keep[i] = keep;
              if (slot_gen[i] == '0) slot_gen[i] = 32'd1;
              live_count++;
            end
          end
          if (i >= 0) begin
            r.idx = 8'(i);
            r.gen = slot_gen[i];
          end else begin
            r.st = gtab_pkg::ST_FULL;
          end
        end
      end
      gtab_pkg::OP_UNREGISTER: begin
        if (key == '0) begin
          r.st = gtab_pkg::ST_NULL;
        end else begin
          i = find_slot(key);
          if (i >= 0) free_slot(i);
          else r.st = gtab_pkg::ST_STALE;
        end
      end
      gtab_pkg::OP_RESOLVE: begin
        if (hgen == '0) r.st = gtab_pkg::ST_NULL;
        else if (hidx >= fill_count || slot_gen[hidx] != hgen || slot_key[hidx] == '0)
          r.st = gtab_pkg::ST_STALE;
        else r.key = slot_key[hidx];
      end
      default: begin
        for (int j = 0; j < fill_count; j++)
          if (slot_key[j] != '0 && !slot_keep[j]) free_slot(j);
      end
    endcase
    r.live = 9'(live_count);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Compare one accepted result with the oldest prediction
  function void check_result(gtab_pkg::status_t st, logic [gtab_pkg::IDX_W-1:0] idx,
                             logic [gtab_pkg::GEN_W-1:0] gen,
                             logic [gtab_pkg::KEY_W-1:0] key,
                             logic [gtab_pkg::CNT_W-1:0] live);
    handle_result_t e;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: status %0d", st);
      return;
    end
    e = pending_results.pop_front();
    if (st !== e.st || idx !== e.idx || gen !== e.gen || key !== e.key || live !== e.live) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"result mismatch: exp st=%0d idx=%0d gen=%0h key=%0h live=%0d, ",
                  "got st=%0d idx=%0d gen=%0h key=%0h live=%0d"},
                 e.st, e.idx, e.gen, e.key, e.live, st, idx, gen, key, live);
    end
  endfunction
endclass

module tb_top;
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [1:0]   m_tuser;

  handle_scoreboard sb = new();
  bit quiet_phase = 0;
  bit hold_start = 0;

  always #1 clk = ~clk;

  generational_handle_table dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(gtab_pkg::status_t'(m_tuser), m_tdata[7:0], m_tdata[39:8],
                      m_tdata[87:40], m_tdata[96:88]);
  end

  // Drive the receiver with random stalls and one long hold-off
  initial begin
    bit held;
    held = 0;
    @(negedge rst);
    forever begin
      if (hold_start && !held) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        held = 1;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one request and note it once accepted
  task automatic send_request(gtab_pkg::opcode_t op, logic [gtab_pkg::KEY_W-1:0] key,
                              logic keep, logic [gtab_pkg::IDX_W-1:0] hidx,
                              logic [gtab_pkg::GEN_W-1:0] hgen);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'b0, hgen, hidx, keep, key};
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, key, keep, hidx, hgen);
    // Drop valid for a random gap now and then
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [gtab_pkg::KEY_W-1:0] fresh_key();
    logic [gtab_pkg::KEY_W-1:0] k;
    k = 48'({$urandom, $urandom});
    if (k == '0) k = 48'd1;
    return k;
  endfunction

  // Pick the key of a live slot, or a fresh one if none is live
  function automatic logic [gtab_pkg::KEY_W-1:0] live_key();
    int i;
    if (sb.live_count == 0) return fresh_key();
    do i = $urandom_range(0, sb.fill_count - 1); while (sb.slot_key[i] == '0);
    return sb.slot_key[i];
  endfunction

  task automatic random_request(int reg_weight);
    int pick;
    int i;
    logic [gtab_pkg::GEN_W-1:0] g;
    pick = $urandom_range(0, 99);
    if (pick < reg_weight) begin
      send_request(gtab_pkg::OP_REGISTER, ($urandom_range(0, 4) == 0) ? live_key() :
                   ($urandom_range(0, 40) == 0) ? 48'd0 : fresh_key(),
                   1'($urandom_range(0, 1)), 8'($urandom), 32'($urandom));
    end else if (pick < reg_weight + (97 - reg_weight) / 2) begin
      send_request(gtab_pkg::OP_UNREGISTER, ($urandom_range(0, 5) == 0) ? fresh_key() :
                   ($urandom_range(0, 40) == 0) ? 48'd0 : live_key(),
                   1'($urandom_range(0, 1)), 8'($urandom), 32'($urandom));
    end else if (pick < 97) begin
      i = $urandom_range(0, 255);
      g = sb.slot_gen[i];
      case ($urandom_range(0, 5))
        0: g = 32'($urandom);
        1: g = g + 32'd1;
        2: g = '0;
        default: ;
      endcase
      send_request(gtab_pkg::OP_RESOLVE, fresh_key(), 1'($urandom_range(0, 1)), 8'(i), g);
    end else begin
      send_request(gtab_pkg::OP_CLEAR, fresh_key(), 1'($urandom_range(0, 1)),
                   8'($urandom), 32'($urandom));
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: null keys, extremes, existing key, stale handles, reuse, clear
    send_request(gtab_pkg::OP_REGISTER, '0, 1'b0, 8'd0, 32'd0);
    send_request(gtab_pkg::OP_REGISTER, '1, 1'b1, 8'hFF, '1);
    send_request(gtab_pkg::OP_REGISTER, 48'd1, 1'b0, 8'd0, 32'd0);
    send_request(gtab_pkg::OP_REGISTER, 48'd1, 1'b1, 8'd0, 32'd0);
    send_request(gtab_pkg::OP_RESOLVE, '0, 1'b0, 8'd1, 32'd1);
    send_request(gtab_pkg::OP_RESOLVE, '0, 1'b0, 8'd0, 32'd0);
    send_request(gtab_pkg::OP_RESOLVE, '0, 1'b0, 8'hFF, '1);
    send_request(gtab_pkg::OP_RESOLVE, '0, 1'b0, 8'd0, 32'd2);
    send_request(gtab_pkg::OP_UNREGISTER, 48'h1234_5678_9ABC, 1'b0, 8'd0, 32'd0);
    send_request(gtab_pkg::OP_UNREGISTER, '0, 1'b0, 8'd0, 32'd0);
    send_request(gtab_pkg::OP_UNREGISTER, 48'd1, 1'b0, 8'd0, 32'd0);
    send_request(gtab_pkg::OP_RESOLVE, '0, 1'b0, 8'd1, 32'd1);
    send_request(gtab_pkg::OP_REGISTER, 48'h8000_0000_0000, 1'b0, 8'd0, 32'd0);
    send_request(gtab_pkg::OP_REGISTER, 48'd2, 1'b0, 8'd0, 32'd0);
    send_request(gtab_pkg::OP_CLEAR, '0, 1'b0, 8'd0, 32'd0);
    send_request(gtab_pkg::OP_RESOLVE, '0, 1'b0, 8'd0, 32'd1);
    send_request(gtab_pkg::OP_UNREGISTER, '1, 1'b0, 8'd0, 32'd0);
    send_request(gtab_pkg::OP_CLEAR, '0, 1'b0, 8'd0, 32'd0);

    // Fill the table past full, then mix everything
    for (int n = 0; n < 1500; n++) begin
      if (n == 700) hold_start = 1;
      if (n == 1350) quiet_phase = 1;
      random_request((n < 400) ? 85 : (n < 500) ? 10 : 35);
    end
    s_tvalid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stop a hung run
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
